@@ hdl/pmu_pkg.sv @@
`default_nettype none
package pmu_pkg;

  // Register indexes of the configuration port (byte address = 4 * index)
  localparam int unsigned REG_LIFESPAN      = 0;
  localparam int unsigned REG_MIN_RADIUS    = 1;
  localparam int unsigned REG_MAX_SPEED     = 2;
  localparam int unsigned REG_MIN_SPEED     = 3;
  localparam int unsigned REG_MAX_DISTANCE  = 4;
  localparam int unsigned REG_PULL_STRENGTH = 5;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned IN_W   = 352;
  localparam int unsigned OUT_W  = 216;

  typedef logic [2:0] reg_idx_t;

  // Fields that travel alongside the long arithmetic chains
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [15:0]      age;
    logic             dead;
  } pmu_pass_t;

  // Saturate a 34-bit signed sum to 32-bit signed
  function automatic logic [31:0] sat32(input logic signed [33:0] x);
    logic [31:0] r;
    if (x > 34'sd2147483647) r = 32'h7FFF_FFFF;
    else if (x < -34'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // Magnitude of a 32-bit signed value; the most negative value maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

endpackage
`default_nettype wire

@@ hdl/pmu_isqrt.sv @@
`default_nettype none
module pmu_isqrt #(
  parameter int unsigned RW = 32,
  parameter int unsigned SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ce,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] radicand,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [RW-1:0]        root,
  output logic [SW-1:0]        side_out
);

  logic          vld  [0:RW];
  logic [RW:0]   rem  [0:RW];
  logic [RW-1:0] rt   [0:RW];
  logic [2*RW-1:0] rad [0:RW];
  logic [SW-1:0] side [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
    if (ce) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      rad[0]  <= radicand;
      side[0] <= side_in;
    end
  end

  // One root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+2:0] trial;
    logic [RW+2:0] sub;
    logic [RW+2:0] diff;
    assign trial = {rem[k], rad[k][2*RW-1 -: 2]};
    assign sub   = {1'b0, rt[k], 2'b01};
    assign diff  = trial - sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
      if (ce) begin
        if (trial >= sub) begin
          rem[k+1] <= diff[RW:0];
          rt[k+1]  <= {rt[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[RW:0];
          rt[k+1]  <= {rt[k][RW-2:0], 1'b0};
        end
        rad[k+1]  <= {rad[k][2*RW-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign side_out  = side[RW];

endmodule
`default_nettype wire

@@ hdl/pmu_div.sv @@
`default_nettype none
module pmu_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire logic             in_valid,
  input  wire logic [DW+QW-1:0] num,
  input  wire logic [DW-1:0]    den,
  input  wire logic [SW-1:0]    side_in,
  output logic                  out_valid,
  output logic [QW-1:0]         quot,
  output logic                  ovf,
  output logic [SW-1:0]         side_out
);

  logic          vld  [0:QW];
  logic          of   [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [DW-1:0] dv   [0:QW];
  logic [SW-1:0] side [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
    if (ce) begin
      // Quotient does not fit in QW bits
      of[0]   <= (num[DW+QW-1:QW] >= den);
      rem[0]  <= num[DW+QW-1:QW];
      low[0]  <= num[QW-1:0];
      q[0]    <= '0;
      dv[0]   <= den;
      side[0] <= side_in;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem[k], low[k][QW-1]};
    assign diff  = trial - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
      if (ce) begin
        if (trial >= {1'b0, dv[k]}) begin
          rem[k+1] <= diff[DW-1:0];
          q[k+1]   <= {q[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[DW-1:0];
          q[k+1]   <= {q[k][QW-2:0], 1'b0};
        end
        low[k+1]  <= {low[k][QW-2:0], 1'b0};
        of[k+1]   <= of[k];
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = q[QW];
  assign ovf       = of[QW];
  assign side_out  = side[QW];

endmodule
`default_nettype wire

@@ hdl/particle_motion_update.sv @@
`default_nettype none
// Particle motion update: one damped Euler step per particle, signed Q16.16.
// A new item can enter every cycle unless the output stalls; each item passes
// through 4 front stages, a 33-stage square root for the distance, 2 stages
// for the center pull gain, a 33-stage divider per axis, 3 stages for the
// speed, a second 33-stage square root, 1 stage, a second 33-stage divider
// and the output register; the roots and dividers resolve one bit per stage.
// The whole pipeline advances together whenever the output register is empty
// or is being taken, so a stall at the output holds every stage and loses
// nothing. Registers sit on an APB port at byte address 4*index; the user must
// write them only while no item is in flight (the block does not enforce this).
module particle_motion_update
  import pmu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Input items
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z (32 each),
  // age_in (16), decay_factor (16), radius_in (31), pad (1)
  input  wire logic [IN_W-1:0]   s_tdata,
  // Result items
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // new_pos_x..z, new_vel_x..z (32 each), age_out (16), dead (1), pad (7)
  output logic [OUT_W-1:0]       m_tdata
);

  localparam logic [30:0] MIN_RADIUS_RST = 31'((64'd1 << FRAC_BITS) / 100);
  localparam logic [30:0] MAX_SPEED_RST  = 31'(64'd10 << FRAC_BITS);
  localparam logic [30:0] MIN_SPEED_RST  = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] MAX_DIST_RST   = 31'(64'd300 << FRAC_BITS);

  localparam int unsigned PW = $bits(pmu_pass_t);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] lifespan;
  logic [30:0] min_radius;
  logic [30:0] max_speed;
  logic [30:0] min_speed;
  logic [30:0] max_distance;
  logic [31:0] pull_strength;
  reg_idx_t    widx;

  assign widx   = paddr[CFG_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifespan      <= 16'd60000;
      min_radius    <= MIN_RADIUS_RST;
      max_speed     <= MAX_SPEED_RST;
      min_speed     <= MIN_SPEED_RST;
      max_distance  <= MAX_DIST_RST;
      pull_strength <= 32'd429497;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        reg_idx_t'(REG_LIFESPAN):      lifespan      <= pwdata[15:0];
        reg_idx_t'(REG_MIN_RADIUS):    min_radius    <= pwdata[30:0];
        reg_idx_t'(REG_MAX_SPEED):     max_speed     <= pwdata[30:0];
        reg_idx_t'(REG_MIN_SPEED):     min_speed     <= pwdata[30:0];
        reg_idx_t'(REG_MAX_DISTANCE):  max_distance  <= pwdata[30:0];
        reg_idx_t'(REG_PULL_STRENGTH): pull_strength <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      reg_idx_t'(REG_LIFESPAN):      prdata = {16'd0, lifespan};
      reg_idx_t'(REG_MIN_RADIUS):    prdata = {1'b0, min_radius};
      reg_idx_t'(REG_MAX_SPEED):     prdata = {1'b0, max_speed};
      reg_idx_t'(REG_MIN_SPEED):     prdata = {1'b0, min_speed};
      reg_idx_t'(REG_MAX_DISTANCE):  prdata = {1'b0, max_distance};
      reg_idx_t'(REG_PULL_STRENGTH): prdata = pull_strength;
      default:                       prdata = '0;
    endcase
  end

  // Squared speed limits, refreshed every cycle from the registers
  logic [61:0] max_sq;
  logic [61:0] min_sq;
  always_ff @(posedge clk) begin
    max_sq <= max_speed * max_speed;
    min_sq <= min_speed * min_speed;
  end

  // ---------------------------------------------------------------------
  // Shared advance: hold everything while the output waits
  // ---------------------------------------------------------------------
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Input unpacking
  logic [2:0][31:0] in_pos, in_vel, in_acc;
  logic [15:0] in_age, in_decay;
  logic [30:0] in_radius;
  logic [15:0] age_inc;

  assign in_pos    = s_tdata[95:0];
  assign in_vel    = s_tdata[191:96];
  assign in_acc    = s_tdata[287:192];
  assign in_age    = s_tdata[303:288];
  assign in_decay  = s_tdata[319:304];
  assign in_radius = s_tdata[350:320];
  assign age_inc   = (in_age == 16'hFFFF) ? in_age : in_age + 16'd1;

  // Stage A: velocity plus acceleration, age and dead flag
  logic             a_vld;
  logic [2:0][31:0] a_pos, a_v1;
  logic [15:0]      a_age, a_decay;
  logic             a_dead;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (ce) begin
      a_vld <= s_tvalid;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a_v1[i] <= sat32(34'(signed'(in_vel[i])) + 34'(signed'(in_acc[i])));
      end
      a_pos   <= in_pos;
      a_age   <= age_inc;
      a_decay <= in_decay;
      a_dead  <= (age_inc > lifespan) || (in_radius < min_radius);
    end
  end

  // Stage B: new position
  logic             b_vld;
  logic [2:0][31:0] b_pos, b_v1;
  logic [15:0]      b_age, b_decay;
  logic             b_dead;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (ce) begin
      b_vld <= a_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b_pos[i] <= sat32(34'(signed'(a_pos[i])) + 34'(signed'(a_v1[i])));
      end
      b_v1    <= a_v1;
      b_age   <= a_age;
      b_decay <= a_decay;
      b_dead  <= a_dead;
    end
  end

  // Stage C: damping (floor of the product) and squared positions
  logic             c_vld;
  pmu_pass_t        c_pass;
  logic [2:0][63:0] c_psq;
  logic signed [48:0] damp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      damp[i] = signed'(b_v1[i]) * signed'({1'b0, b_decay});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (ce) begin
      c_vld <= b_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        c_pass.vel[i] <= damp[i][47:16];
        c_psq[i]      <= mag32(b_pos[i]) * mag32(b_pos[i]);
      end
      c_pass.pos  <= b_pos;
      c_pass.age  <= b_age;
      c_pass.dead <= b_dead;
    end
  end

  // Stage D: squared distance
  logic      d_vld;
  pmu_pass_t d_pass;
  logic [63:0] d_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (ce) begin
      d_vld <= c_vld;
    end
    if (ce) begin
      d_d2   <= c_psq[0] + c_psq[1] + c_psq[2];
      d_pass <= c_pass;
    end
  end

  // Distance from the origin
  logic          s1_vld;
  logic [31:0]   s1_dist;
  logic [PW-1:0] s1_side;

  pmu_isqrt #(.RW(32), .SW(PW)) u_dist_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (d_vld),
    .radicand  (d_d2),
    .side_in   (d_pass),
    .out_valid (s1_vld),
    .root      (s1_dist),
    .side_out  (s1_side)
  );

  // Stage E: excess distance times pull gain
  logic      e_vld;
  pmu_pass_t e_pass;
  logic      e_pull;
  logic [31:0] e_dist;
  logic [63:0] e_mprod;
  logic [31:0] e_excess;

  assign e_excess = s1_dist - {1'b0, max_distance};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (ce) begin
      e_vld <= s1_vld;
    end
    if (ce) begin
      e_pull  <= s1_dist > {1'b0, max_distance};
      e_mprod <= e_excess * pull_strength;
      e_dist  <= s1_dist;
      e_pass  <= s1_side;
    end
  end

  // Stage F: per-axis pull numerator; divisor is the distance
  logic      f_vld;
  pmu_pass_t f_pass;
  logic      f_pull;
  logic [31:0] f_den;
  logic [2:0][63:0] f_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (ce) begin
      f_vld <= e_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        f_num[i] <= e_pull ? mag32(e_pass.pos[i]) * e_mprod[63:32] : 64'd0;
      end
      f_den  <= e_pull ? e_dist : 32'd1;
      f_pull <= e_pull;
      f_pass <= e_pass;
    end
  end

  // Pull dividers, one per axis; lane 0 carries the item
  logic          q1_vld;
  logic [2:0][31:0] q1;
  logic [PW:0]   q1_side;

  pmu_div #(.DW(32), .QW(32), .SW(PW + 1)) u_pull_div0 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_vld),
    .num       (f_num[0]),
    .den       (f_den),
    .side_in   ({f_pass, f_pull}),
    .out_valid (q1_vld),
    .quot      (q1[0]),
    .ovf       (),
    .side_out  (q1_side)
  );

  for (genvar g = 1; g < 3; g++) begin : g_pull_div
    pmu_div #(.DW(32), .QW(32), .SW(1)) u_pull_div (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (f_vld),
      .num       (f_num[g]),
      .den       (f_den),
      .side_in   (1'b0),
      .out_valid (),
      .quot      (q1[g]),
      .ovf       (),
      .side_out  ()
    );
  end

  // Stage G: apply center pull
  logic      g_vld;
  pmu_pass_t g_pass, q1_pass, g_pass_next;
  logic      q1_pull;
  logic signed [33:0] pq [3];

  assign q1_pass = q1_side[PW:1];
  assign q1_pull = q1_side[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pq[i] = q1_pass.pos[i][31] ? -signed'({2'b00, q1[i]}) : signed'({2'b00, q1[i]});
    end
  end

  always_comb begin
    g_pass_next = q1_pass;
    for (int i = 0; i < 3; i++) begin
      if (q1_pull) begin
        g_pass_next.vel[i] = sat32(34'(signed'(q1_pass.vel[i])) - pq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (ce) begin
      g_vld <= q1_vld;
    end
    if (ce) begin
      g_pass <= g_pass_next;
    end
  end

  // Stage H: squared velocity per axis
  logic      h_vld;
  pmu_pass_t h_pass;
  logic [2:0][63:0] h_vsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (ce) begin
      h_vld <= g_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        h_vsq[i] <= mag32(g_pass.vel[i]) * mag32(g_pass.vel[i]);
      end
      h_pass <= g_pass;
    end
  end

  // Stage I: squared speed against the limits; upper limit wins
  logic      i_vld;
  pmu_pass_t i_pass;
  logic [63:0] i_s2;
  logic        i_clamp;
  logic [30:0] i_target;
  logic [63:0] s2_sum;

  assign s2_sum = h_vsq[0] + h_vsq[1] + h_vsq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (ce) begin
      i_vld <= h_vld;
    end
    if (ce) begin
      i_s2   <= s2_sum;
      i_pass <= h_pass;
      if (s2_sum > {2'b00, max_sq}) begin
        i_clamp  <= 1'b1;
        i_target <= max_speed;
      end else if (s2_sum < {2'b00, min_sq} && s2_sum != 64'd0) begin
        i_clamp  <= 1'b1;
        i_target <= min_speed;
      end else begin
        i_clamp  <= 1'b0;
        i_target <= '0;
      end
    end
  end

  // Speed
  logic          s2_vld;
  logic [31:0]   s2_speed;
  logic [PW+31:0] s2_side;

  pmu_isqrt #(.RW(32), .SW(PW + 32)) u_speed_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (i_vld),
    .radicand  (i_s2),
    .side_in   ({i_pass, i_clamp, i_target}),
    .out_valid (s2_vld),
    .root      (s2_speed),
    .side_out  (s2_side)
  );

  // Stage J: rescale numerators; divisor is the speed
  logic      j_vld;
  pmu_pass_t j_pass, s2_pass;
  logic      j_clamp, s2_clamp;
  logic [30:0] s2_target;
  logic [31:0] j_den;
  logic [2:0][63:0] j_num;

  assign s2_pass   = s2_side[PW+31:32];
  assign s2_clamp  = s2_side[31];
  assign s2_target = s2_side[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (ce) begin
      j_vld <= s2_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        j_num[i] <= s2_clamp ? 64'(mag32(s2_pass.vel[i]) * s2_target) : 64'd0;
      end
      j_den   <= s2_clamp ? s2_speed : 32'd1;
      j_clamp <= s2_clamp;
      j_pass  <= s2_pass;
    end
  end

  // Clamp dividers; quotient overflow saturates
  logic          q2_vld;
  logic [2:0][31:0] q2;
  logic [2:0]    q2_ovf;
  logic [PW:0]   q2_side;

  pmu_div #(.DW(32), .QW(32), .SW(PW + 1)) u_clamp_div0 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (j_vld),
    .num       (j_num[0]),
    .den       (j_den),
    .side_in   ({j_pass, j_clamp}),
    .out_valid (q2_vld),
    .quot      (q2[0]),
    .ovf       (q2_ovf[0]),
    .side_out  (q2_side)
  );

  for (genvar g = 1; g < 3; g++) begin : g_clamp_div
    pmu_div #(.DW(32), .QW(32), .SW(1)) u_clamp_div (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (j_vld),
      .num       (j_num[g]),
      .den       (j_den),
      .side_in   (1'b0),
      .out_valid (),
      .quot      (q2[g]),
      .ovf       (q2_ovf[g]),
      .side_out  ()
    );
  end

  // Stage K: output register
  pmu_pass_t q2_pass, k_pass, k_pass_next;
  logic      q2_clamp;

  assign q2_pass  = q2_side[PW:1];
  assign q2_clamp = q2_side[0];

  always_comb begin
    k_pass_next = q2_pass;
    for (int i = 0; i < 3; i++) begin
      if (q2_clamp) begin
        if (q2_pass.vel[i][31]) begin
          k_pass_next.vel[i] = (q2_ovf[i] || q2[i][31]) ? 32'h8000_0000 : 32'd0 - q2[i];
        end else begin
          k_pass_next.vel[i] = (q2_ovf[i] || q2[i][31]) ? 32'h7FFF_FFFF : q2[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= q2_vld;
    end
    if (ce) begin
      k_pass <= k_pass_next;
    end
  end

  assign m_tdata = {7'd0, k_pass.dead, k_pass.age, k_pass.vel, k_pass.pos};

endmodule
`default_nettype wire

@@ tb/tb_particle_motion_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Holds the register copy and the queue of particles still to come out.
class particle_board;
  logic [15:0] lifespan;
  logic [30:0] min_radius;
  logic [30:0] max_speed;
  logic [30:0] min_speed;
  logic [30:0] max_distance;
  logic [31:0] pull_strength;
  logic [215:0] pending_q[$];
  int errors;

  function new();
    errors = 0;
    lifespan = 16'd60000;
    min_radius = 31'd655;
    max_speed = 31'd655360;
    min_speed = 31'd65536;
    max_distance = 31'd19660800;
    pull_strength = 32'd429497;
  endfunction

  function void write_reg(int unsigned idx, logic [31:0] val);
    case (idx)
      pmu_pkg::REG_LIFESPAN:      lifespan = val[15:0];
      pmu_pkg::REG_MIN_RADIUS:    min_radius = val[30:0];
      pmu_pkg::REG_MAX_SPEED:     max_speed = val[30:0];
      pmu_pkg::REG_MIN_SPEED:     min_speed = val[30:0];
      pmu_pkg::REG_MAX_DISTANCE:  max_distance = val[30:0];
      pmu_pkg::REG_PULL_STRENGTH: pull_strength = val;
      default: ;
    endcase
  endfunction

  static function longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  static function longint unsigned absv(longint x);
    return x < 0 ? -x : x;
  endfunction

  static function longint unsigned root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function longint ratio(longint v, longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = absv(v) * num / den;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Work out the updated particle for one accepted item
  function void note_particle(logic [351:0] d);
    longint p[3], v[3], v1;
    longint unsigned d2, s2, reach, gain, tgt, spd;
    logic [15:0] age;
    logic [215:0] r;
    bit dead;
    d2 = 0;
    s2 = 0;
    age = d[303:288];
    age = (age == 16'hFFFF) ? age : age + 1;
    for (int i = 0; i < 3; i++) begin
      v1 = clip32(longint'($signed(d[96+32*i +: 32])) + longint'($signed(d[192+32*i +: 32])));
      p[i] = clip32(longint'($signed(d[32*i +: 32])) + v1);
      v[i] = (v1 * longint'({48'd0, d[319:304]})) >>> 16;
      d2 += absv(p[i]) * absv(p[i]);
    end
    reach = root(d2);
    if (reach > max_distance) begin
      gain = ((reach - max_distance) * pull_strength) >> 32;
      for (int i = 0; i < 3; i++) v[i] = clip32(v[i] - ratio(p[i], gain, reach));
    end
    for (int i = 0; i < 3; i++) s2 += absv(v[i]) * absv(v[i]);
    tgt = 0;
    if (s2 > longint'(max_speed) * max_speed) tgt = max_speed;
    else if (s2 < longint'(min_speed) * min_speed && s2 != 0) tgt = min_speed;
    if (s2 > longint'(max_speed) * max_speed ||
        (s2 < longint'(min_speed) * min_speed && s2 != 0)) begin
      spd = root(s2);
      for (int i = 0; i < 3; i++) v[i] = clip32(ratio(v[i], tgt, spd));
    end
    dead = (age > lifespan) || (d[350:320] < min_radius);
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r[32*i +: 32] = p[i][31:0];
      r[96+32*i +: 32] = v[i][31:0];
    end
    r[207:192] = age;
    r[208] = dead;
    pending_q.push_back(r);
  endfunction

  function void check_particle(logic [215:0] got);
    logic [215:0] exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    for (int f = 0; f < 6; f++)
      if (got[32*f +: 32] !== exp_r[32*f +: 32]) begin
        $display("%0t: field %0d expected %h actual %h", $time, f,
                 exp_r[32*f +: 32], got[32*f +: 32]);
        errors++;
      end
    if (got[207:192] !== exp_r[207:192]) begin
      $display("%0t: age_out expected %h actual %h", $time, exp_r[207:192], got[207:192]);
      errors++;
    end
    if (got[208] !== exp_r[208]) begin
      $display("%0t: dead expected %b actual %b", $time, exp_r[208], got[208]);
      errors++;
    end
  endfunction
endclass

module tb_particle_motion_update;
  import pmu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Idle odds in percent for each side; a hold-off count for the long stall
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  particle_board board = new();

  always #2 clk = ~clk;

  particle_motion_update u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Note each accepted item and check each accepted result at the edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_particle(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_particle(m_tdata);
  end

  // Receiver: stall at random, or hold off completely during a long stretch
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Setup cycle then access cycle; the register lands on the access edge
  task automatic reg_write(int unsigned idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one item, keeping valid up until it is taken
  task automatic send_particle(logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(int'($urandom_range(2000000)) - 1000000);
      2: return 32'(int'($urandom_range(60000000)) - 30000000);
      default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Build a particle: mostly realistic magnitudes, some full-range noise
  function automatic logic [IN_W-1:0] rand_particle();
    logic [IN_W-1:0] d;
    int mode;
    d = '0;
    for (int i = 0; i < 9; i++) begin
      mode = $urandom_range(9);
      mode = (mode < 2) ? 0 : (mode < 5) ? 1 : (mode < 9) ? 2 : 3;
      if (i >= 3 && $urandom_range(19) == 0) d[32*i +: 32] = '0;
      else d[32*i +: 32] = rand_word(mode);
    end
    d[303:288] = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom());
    d[319:304] = 16'($urandom());
    d[350:320] = ($urandom_range(1)) ? 31'($urandom_range(2000)) : 31'($urandom());
    return d;
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_particle(rand_particle());
  endtask

  initial begin
    logic [IN_W-1:0] d;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the default settings: zero, extremes, saturation
    send_particle('0);
    d = '0;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = 32'h7FFF_FFFF;
    d[303:288] = 16'hFFFF;
    d[319:304] = 16'hFFFF;
    d[350:320] = 31'h7FFF_FFFF;
    send_particle(d);
    for (int i = 0; i < 9; i++) d[32*i +: 32] = 32'h8000_0000;
    d[303:288] = 16'd60000;
    d[350:320] = 31'd654;
    send_particle(d);
    d = '0;
    d[127:96] = 32'd1000;
    d[319:304] = 16'hFFFF;
    d[303:288] = 16'd59999;
    d[350:320] = 31'd655;
    send_particle(d);
    d[31:0] = 32'd400 << 16;
    d[127:96] = 32'd50 << 16;
    send_particle(d);
    d[31:0] = 32'hFE70_0000;
    d[159:128] = 32'hFFFF_0000;
    send_particle(d);
    for (int k = 0; k < 12; k++) send_particle(rand_particle());
    go_idle();

    // Crossed speed limits, zero max speed, extreme registers
    reg_write(REG_MIN_SPEED, 32'h7FFF_FFFF);
    reg_write(REG_MAX_SPEED, 32'd100000);
    reg_write(REG_LIFESPAN, 32'd0);
    reg_write(REG_MIN_RADIUS, 32'h7FFF_FFFF);
    for (int k = 0; k < 4; k++) send_particle(rand_particle());
    go_idle();
    reg_write(REG_MAX_SPEED, 32'd0);
    reg_write(REG_MIN_SPEED, 32'd0);
    reg_write(REG_LIFESPAN, 32'hFFFF);
    reg_write(REG_MIN_RADIUS, 32'd0);
    reg_write(REG_MAX_DISTANCE, 32'd0);
    reg_write(REG_PULL_STRENGTH, 32'hFFFF_FFFF);
    for (int k = 0; k < 4; k++) send_particle(rand_particle());
    go_idle();

    // Random phases, each at its own settings and idle pattern
    send_idle = 37;
    recv_idle = 69;
    reg_write(REG_MAX_SPEED, 32'h7FFF_FFFF);
    reg_write(REG_MAX_DISTANCE, 32'h7FFF_FFFF);
    reg_write(REG_PULL_STRENGTH, 32'd0);
    random_phase(350);
    go_idle();

    send_idle = 69;
    recv_idle = 37;
    reg_write(REG_LIFESPAN, 32'd60000);
    reg_write(REG_MIN_RADIUS, 32'd655);
    reg_write(REG_MAX_SPEED, 32'd655360);
    reg_write(REG_MIN_SPEED, 32'd65536);
    reg_write(REG_MAX_DISTANCE, 32'd19660800);
    reg_write(REG_PULL_STRENGTH, 32'd429497);
    random_phase(400);
    go_idle();

    // No idling; stall the receiver long enough to back up the pipeline
    send_idle = 0;
    recv_idle = 0;
    reg_write(REG_MAX_SPEED, 32'($urandom_range(5000000)));
    reg_write(REG_MIN_SPEED, 32'($urandom_range(100000)));
    reg_write(REG_MAX_DISTANCE, 32'($urandom_range(40000000)));
    reg_write(REG_PULL_STRENGTH, $urandom());
    reg_write(REG_LIFESPAN, 32'($urandom_range(65535)));
    hold_cycles = 400;
    random_phase(770);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire
